// File: rtl/core/hmu_pkg.sv
// ============================================================================
// hmu_pkg: shared types and constants
// Holds the request codes, the lattice size, the queue entry type and the exp
// table used by the Metropolis update block.
// ============================================================================
package hmu_pkg;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // Lattice edge length; the site addresses are the packed coordinates.
    localparam int EDGE = 64;

    localparam int unsigned LOG2E_Q14 = 23637;

    // One classified item handed from the front part to the back part.
    typedef struct packed {
        logic [1:0]         req;
        logic [17:0]        site;
        logic [17:0]        xp;
        logic [17:0]        xm;
        logic [17:0]        yp;
        logic [17:0]        ym;
        logic [17:0]        zp;
        logic [17:0]        zm;
        logic               occ;
        logic signed [15:0] va;
        logic signed [15:0] vb;
        logic signed [15:0] vc;
        logic [15:0]        rnd;
    } t_cmd;

    // 2^(-k/16) in Q1.16.
    function automatic logic [16:0] pow2_frac(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd62757;
            4'd2:    v = 17'd60097;
            4'd3:    v = 17'd57549;
            4'd4:    v = 17'd55109;
            4'd5:    v = 17'd52773;
            4'd6:    v = 17'd50535;
            4'd7:    v = 17'd48393;
            4'd8:    v = 17'd46341;
            4'd9:    v = 17'd44376;
            4'd10:   v = 17'd42495;
            4'd11:   v = 17'd40693;
            4'd12:   v = 17'd38968;
            4'd13:   v = 17'd37316;
            4'd14:   v = 17'd35734;
            default: v = 17'd34219;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/hmu_front.sv
// ============================================================================
// hmu_front: input stage and command queue
// Accepts items, wraps coordinates, works out the six neighbour addresses
// and holds classified items in a short queue for the back part.
// ============================================================================
module hmu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    i_req_type,
    input  logic [5:0]    i_site_x,
    input  logic [5:0]    i_site_y,
    input  logic [5:0]    i_site_z,
    input  logic          i_occupied_in,
    input  logic signed [15:0] i_vec_a,
    input  logic signed [15:0] i_vec_b,
    input  logic signed [15:0] i_vec_c,
    input  logic [15:0]   i_rand_uniform,
    output logic          o_cmd_valid,
    output hmu_pkg::t_cmd o_cmd,
    input  logic          i_cmd_take
);
    import hmu_pkg::*;

    localparam int CW = $clog2(EDGE);
    localparam int DEPTH = 4;

    logic [CW-1:0] x, y, z;
    t_cmd c;
    t_cmd r_q [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    function automatic logic [CW-1:0] wrap(input logic [5:0] v);
        logic [6:0] t;
        t = {1'b0, v};
        if (t >= 7'(EDGE)) t = t - 7'(EDGE);
        return t[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] inc(input logic [CW-1:0] v);
        return (v == CW'(EDGE - 1)) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [CW-1:0] dec(input logic [CW-1:0] v);
        return (v == '0) ? CW'(EDGE - 1) : v - 1'b1;
    endfunction

    function automatic logic [17:0] idx(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                        input logic [CW-1:0] d);
        logic [3*CW-1:0] t;
        t = {a, b, d};
        return 18'(t);
    endfunction

    // Classify the item and form all addresses it will need.
    always_comb begin
        x = wrap(i_site_x);
        y = wrap(i_site_y);
        z = wrap(i_site_z);
        c.req  = (i_req_type == 2'd3) ? REQ_READ : i_req_type;
        c.site = idx(x, y, z);
        c.xp   = idx(inc(x), y, z);
        c.xm   = idx(dec(x), y, z);
        c.yp   = idx(x, inc(y), z);
        c.ym   = idx(x, dec(y), z);
        c.zp   = idx(x, y, inc(z));
        c.zm   = idx(x, y, dec(z));
        c.occ  = i_occupied_in;
        c.va   = i_vec_a;
        c.vb   = i_vec_b;
        c.vc   = i_vec_c;
        c.rnd  = i_rand_uniform;
    end

    assign full = (r_cnt == 3'(DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd = r_q[r_rp];

    // Command queue.
    always_ff @(posedge i_clk) begin
        if (push && !full) r_q[r_wp] <= c;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push && !full) r_wp <= r_wp + 1'b1;
            if (i_cmd_take && o_cmd_valid) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 3'(push && !full) - 3'(i_cmd_take && o_cmd_valid);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(DEPTH)) else $error("queue count overflow");
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !o_cmd_valid) else $error("valid while empty");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !(i_cmd_take && o_cmd_valid)) |=> full) else $error("full dropped");

endmodule

// File: rtl/core/hmu_back.sv
// ============================================================================
// hmu_back: lattice memory and update sequencer
// Carries out load, read and update commands against the lattice memory,
// one memory access a cycle, and presents one result item per command.
// ============================================================================
module hmu_back #(
    parameter int SPIN_FRAC_BITS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  hmu_pkg::t_cmd i_cmd,
    output logic          o_cmd_take,
    input  logic [15:0]   i_inv_t,
    output logic          empty,
    input  logic          pop,
    output logic signed [15:0] o_spin_x_out,
    output logic signed [15:0] o_spin_y_out,
    output logic signed [15:0] o_spin_z_out,
    output logic          o_occupied_out,
    output logic          o_accepted,
    output logic signed [18:0] o_energy_change
);
    import hmu_pkg::*;

    localparam int F = SPIN_FRAC_BITS;
    localparam int SITES = EDGE * EDGE * EDGE;
    localparam int AW = $clog2(SITES);
    localparam int DW = 34 - F;
    localparam longint LIM = (F < 15) ? (64'sd1 <<< F) : 64'sd32767;
    localparam longint ELIM = ((64'sd12 <<< F) > 262143) ? 64'sd262143 : (64'sd12 <<< F);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_SELF = 4'd2;
    localparam logic [3:0] S_NB   = 4'd3;
    localparam logic [3:0] S_DOT  = 4'd4;
    localparam logic [3:0] S_REF  = 4'd5;
    localparam logic [3:0] S_DE   = 4'd6;
    localparam logic [3:0] S_EXP1 = 4'd7;
    localparam logic [3:0] S_EXP2 = 4'd8;
    localparam logic [3:0] S_DEC  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [48:0] r_mem [SITES];
    logic [48:0] r_rdata;
    logic [3:0]  r_state;
    t_cmd        r_cmd;
    logic [2:0]  r_nb;
    logic [AW-1:0] rd_addr;
    logic        rd_en;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [48:0] wr_data;

    logic signed [15:0] r_s [3];
    logic signed [20:0] r_acc [3];
    logic signed [DW-1:0] r_d;
    logic signed [16:0] r_ns [3];
    logic signed [19:0] r_de;
    logic [49:0] r_prod;
    logic        r_acc_flag;
    logic        r_occ;
    logic [48:0] r_res;
    logic        r_res_v;
    logic [63:0] yq;
    logic [63:0] p_val;

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
        return (v + (64'sd1 <<< (F - 1))) >>> F;
    endfunction

    function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                               input logic signed [63:0] l);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    function automatic logic [AW-1:0] nb_addr(input t_cmd c, input logic [2:0] k);
        logic [17:0] a;
        case (k)
            3'd0:    a = c.xp;
            3'd1:    a = c.xm;
            3'd2:    a = c.yp;
            3'd3:    a = c.ym;
            3'd4:    a = c.zp;
            default: a = c.zm;
        endcase
        return a[AW-1:0];
    endfunction

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid && !r_res_v;
    assign empty = !r_res_v;
    assign o_spin_x_out = r_res[15:0];
    assign o_spin_y_out = r_res[31:16];
    assign o_spin_z_out = r_res[47:32];
    assign o_occupied_out = r_res[48];

    // Memory address selection.
    always_comb begin
        rd_en = 1'b0;
        rd_addr = r_cmd.site[AW-1:0];
        wr_en = 1'b0;
        wr_addr = r_cmd.site[AW-1:0];
        wr_data = {1'b1, r_ns[2][15:0], r_ns[1][15:0], r_ns[0][15:0]};
        case (r_state)
            S_RD: begin
                if (r_cmd.req == REQ_LOAD) begin
                    wr_en = 1'b1;
                    wr_data = {r_cmd.occ, r_cmd.vc, r_cmd.vb, r_cmd.va};
                end else begin
                    rd_en = 1'b1;
                end
            end
            S_SELF, S_NB: begin
                rd_en = (r_nb != 3'd6);
                rd_addr = nb_addr(r_cmd, r_nb);
            end
            S_OUT: wr_en = r_acc_flag;
            default: ;
        endcase
    end

    // Lattice memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    // Update path: read site, six neighbours, reflect, dE, exp test, write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res_v <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_cmd <= i_cmd;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_nb <= '0;
                    r_de <= '0;
                    r_acc_flag <= 1'b0;
                    if (r_cmd.req == REQ_LOAD) begin
                        r_res <= {r_cmd.occ, r_cmd.vc, r_cmd.vb, r_cmd.va};
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SELF;
                    end
                end
                S_SELF: begin
                    r_res <= r_rdata;
                    r_occ <= r_rdata[48];
                    r_s[0] <= r_rdata[15:0];
                    r_s[1] <= r_rdata[31:16];
                    r_s[2] <= r_rdata[47:32];
                    for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                    r_nb <= 3'd1;
                    if (r_cmd.req == REQ_UPDATE && r_rdata[48]) r_state <= S_NB;
                    else r_state <= S_OUT;
                end
                S_NB: begin
                    if (r_rdata[48]) begin
                        r_acc[0] <= r_acc[0] + 21'(signed'(r_rdata[15:0]));
                        r_acc[1] <= r_acc[1] + 21'(signed'(r_rdata[31:16]));
                        r_acc[2] <= r_acc[2] + 21'(signed'(r_rdata[47:32]));
                    end
                    if (r_nb == 3'd6) r_state <= S_DOT;
                    else r_nb <= r_nb + 1'b1;
                end
                S_DOT: begin
                    r_d <= DW'(rnd(64'(r_s[0] * r_cmd.va) + 64'(r_s[1] * r_cmd.vb)
                                   + 64'(r_s[2] * r_cmd.vc)));
                    r_state <= S_REF;
                end
                S_REF: begin
                    r_ns[0] <= 17'(sat(rnd(2 * r_d * 64'(r_cmd.va)) - 64'(r_s[0]), LIM));
                    r_ns[1] <= 17'(sat(rnd(2 * r_d * 64'(r_cmd.vb)) - 64'(r_s[1]), LIM));
                    r_ns[2] <= 17'(sat(rnd(2 * r_d * 64'(r_cmd.vc)) - 64'(r_s[2]), LIM));
                    r_state <= S_DE;
                end
                S_DE: begin
                    r_de <= 20'(sat(rnd((64'(r_s[0]) - 64'(r_ns[0])) * 64'(r_acc[0])
                                      + (64'(r_s[1]) - 64'(r_ns[1])) * 64'(r_acc[1])
                                      + (64'(r_s[2]) - 64'(r_ns[2])) * 64'(r_acc[2])),
                                    ELIM));
                    r_state <= S_EXP1;
                end
                S_EXP1: begin
                    r_prod <= 50'(r_de[18:0] * i_inv_t);
                    r_state <= S_EXP2;
                end
                S_EXP2: begin
                    r_prod <= 50'(r_prod[34:0] * 15'(LOG2E_Q14));
                    r_state <= S_DEC;
                end
                S_DEC: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_res_v || pop) begin
                        o_accepted <= r_acc_flag;
                        o_energy_change <= r_de[18:0];
                        if (r_acc_flag) r_res <= wr_data;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // Result flag: set when a result is loaded, cleared when it is taken.
            if (r_state == S_OUT && (!r_res_v || pop)) r_res_v <= 1'b1;
            else if (pop && r_res_v) r_res_v <= 1'b0;
            // Acceptance decision: in S_EXP2 for dE <= 0, in S_DEC for dE > 0.
            if (r_state == S_EXP2 && r_de <= 0) r_acc_flag <= 1'b1;
            if (r_state == S_DEC && r_de > 0) begin
                r_acc_flag <= ({48'd0, r_cmd.rnd} <= p_val);
            end
        end
    end

    always_comb begin
        yq = (64'(r_prod) + (64'd1 << (F + 21))) >> (F + 22);
        p_val = (yq[63:4] <= 60'd16) ? (64'(pow2_frac(yq[3:0])) >> yq[63:4]) : 64'd0;
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> (r_state == S_IDLE)) else $error("take while busy");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_v && !pop) |=> r_res_v) else $error("result lost");
    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_RD || r_state == S_OUT)) else $error("stray write");

endmodule

// File: rtl/core/heisenberg_metropolis_update_top.sv
// ============================================================================
// heisenberg_metropolis_update_top: Metropolis update for a 3D Heisenberg lattice
// Top level tying the input queue, the configuration register and the back part.
// ============================================================================
// A load writes the lattice memory and goes straight to its result. A read uses
// the lattice memory read port for the site; an update uses it once for the
// site and, if the site is occupied, once for each of six neighbours, then the
// reflection, energy and exp test steps run one step a cycle. Items queue up
// to four deep in front while the back part is busy or a result waits. The
// lattice memory is undefined until written; inv_temperature resets to 5933.
module heisenberg_metropolis_update_top #(
    parameter int SPIN_FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [5:0]  i_site_x,
    input  logic [5:0]  i_site_y,
    input  logic [5:0]  i_site_z,
    input  logic        i_occupied_in,
    input  logic signed [15:0] i_vec_a,
    input  logic signed [15:0] i_vec_b,
    input  logic signed [15:0] i_vec_c,
    input  logic [15:0] i_rand_uniform,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic signed [15:0] o_spin_x_out,
    output logic signed [15:0] o_spin_y_out,
    output logic signed [15:0] o_spin_z_out,
    output logic        o_occupied_out,
    output logic        o_accepted,
    output logic signed [18:0] o_energy_change
);
    import hmu_pkg::*;

    logic  cmd_valid, cmd_take;
    t_cmd  cmd;
    logic [15:0] r_inv_t;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_inv_t <= 16'd5933;
        else if (i_cfg_we) r_inv_t <= i_cfg_data;
    end

    hmu_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_req_type, .i_site_x, .i_site_y,
        .i_site_z, .i_occupied_in, .i_vec_a, .i_vec_b, .i_vec_c, .i_rand_uniform,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    hmu_back #(.SPIN_FRAC_BITS(SPIN_FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_take(cmd_take), .i_inv_t(r_inv_t), .empty, .pop,
        .o_spin_x_out, .o_spin_y_out, .o_spin_z_out, .o_occupied_out,
        .o_accepted, .o_energy_change
    );

endmodule
